### design/tpc_pkg.sv
`default_nettype none
package tpc_pkg;

    localparam int CFG_W                = 8;
    localparam int ELEM_W               = 16;
    localparam int COUNT_W              = 16;
    localparam int STATUS_W             = 2;
    localparam int DEFAULT_MAX_ELEMENTS = 128;
    localparam int N_MIN                = 2;
    localparam logic [CFG_W-1:0] CFG_RESET = 8'd128;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_ZERO  = 2'd1,
        STAT_ABOVE = 2'd2,
        STAT_EQUAL = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } t_back_state;

    function automatic int table_depth(input int max_elements);
        return (max_elements * (max_elements - 1)) / 2;
    endfunction

    function automatic int addr_width(input int max_elements);
        int depth;
        depth = (max_elements * (max_elements - 1)) / 2;
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

endpackage
`default_nettype wire

### design/tpc_front.sv
`default_nettype none
module tpc_front #(
    parameter int MAX_ELEMENTS = tpc_pkg::DEFAULT_MAX_ELEMENTS,
    parameter int AW           = tpc_pkg::addr_width(tpc_pkg::DEFAULT_MAX_ELEMENTS)
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire logic                        i_mode,
    input  wire logic [tpc_pkg::ELEM_W-1:0]  i_first_element,
    input  wire logic [tpc_pkg::ELEM_W-1:0]  i_second_element,
    input  wire logic [tpc_pkg::COUNT_W-1:0] i_delta,
    input  wire logic                        i_cfg_we,
    input  wire logic [tpc_pkg::CFG_W-1:0]   i_cfg_data,
    input  wire logic                        i_hold,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output logic                             o_mode,
    output tpc_pkg::t_status                 o_status,
    output logic [tpc_pkg::COUNT_W-1:0]      o_delta,
    output logic [AW-1:0]                    o_idx
);
    import tpc_pkg::*;

    localparam int EW = $clog2(MAX_ELEMENTS + 1);
    localparam int CW = (EW > CFG_W) ? EW : CFG_W;
    localparam int PW = 2 * EW;

    logic [CFG_W-1:0] r_cfg;
    logic [CW-1:0]    w_cfg_ext;
    logic [EW-1:0]    w_n;
    logic [ELEM_W-1:0] w_n16, w_a, w_b, w_dba;
    t_status          w_status;

    logic             r1_valid, r1_mode;
    t_status          r1_status;
    logic [COUNT_W-1:0] r1_delta;
    logic [EW-1:0]    r1_am1, r1_a, r1_n, r1_dba;

    logic             r2_valid, r2_mode;
    t_status          r2_status;
    logic [COUNT_W-1:0] r2_delta;
    logic [PW-1:0]    r2_p1, r2_p2;
    logic [EW-1:0]    r2_dba;

    logic w_s2_ready, w_s1_adv, w_s1_ready, w_in_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            r_cfg <= i_cfg_data;
        end
    end

    always_comb begin
        w_cfg_ext = CW'(r_cfg);
        if (w_cfg_ext < CW'(N_MIN)) begin
            w_n = EW'(N_MIN);
        end else if (w_cfg_ext > CW'(MAX_ELEMENTS)) begin
            w_n = EW'(MAX_ELEMENTS);
        end else begin
            w_n = EW'(w_cfg_ext);
        end
        w_n16 = ELEM_W'(w_n);
        if (i_first_element == '0 || i_second_element == '0) begin
            w_status = STAT_ZERO;
        end else if (i_first_element > w_n16 || i_second_element > w_n16) begin
            w_status = STAT_ABOVE;
        end else if (i_first_element == i_second_element) begin
            w_status = STAT_EQUAL;
        end else begin
            w_status = STAT_OK;
        end
        w_a   = (i_first_element < i_second_element) ? i_first_element : i_second_element;
        w_b   = (i_first_element < i_second_element) ? i_second_element : i_first_element;
        w_dba = w_b - w_a - ELEM_W'(1);
    end

    assign w_s2_ready = !r2_valid || i_ready;
    assign w_s1_adv   = r1_valid && w_s2_ready;
    assign w_s1_ready = !r1_valid || w_s2_ready;
    assign o_ready    = w_s1_ready && !i_hold;
    assign w_in_acc   = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
        end else begin
            if (w_in_acc) begin
                r1_valid <= 1'b1;
            end else if (w_s1_adv) begin
                r1_valid <= 1'b0;
            end
            if (w_s1_adv) begin
                r2_valid <= 1'b1;
            end else if (i_ready) begin
                r2_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r1_mode   <= i_mode;
            r1_status <= w_status;
            r1_delta  <= i_delta;
            r1_a      <= w_a[EW-1:0];
            r1_am1    <= w_a[EW-1:0] - EW'(1);
            r1_n      <= w_n;
            r1_dba    <= w_dba[EW-1:0];
        end
        if (w_s1_adv) begin
            r2_mode   <= r1_mode;
            r2_status <= r1_status;
            r2_delta  <= r1_delta;
            r2_p1     <= PW'(r1_am1) * PW'(r1_n);
            r2_p2     <= PW'(r1_am1) * PW'(r1_a);
            r2_dba    <= r1_dba;
        end
    end

    assign o_valid  = r2_valid;
    assign o_mode   = r2_mode;
    assign o_status = r2_status;
    assign o_delta  = r2_delta;
    assign o_idx    = AW'(r2_p1 - (r2_p2 >> 1) + PW'(r2_dba));

endmodule
`default_nettype wire

### design/tpc_queue.sv
`default_nettype none
module tpc_queue #(
    parameter int W = 8
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    output logic              o_ready,
    input  wire logic [W-1:0] i_data,
    output logic              o_valid,
    input  wire logic         i_ready,
    output logic [W-1:0]      o_data
);
    import tpc_pkg::*;

    logic [W-1:0] r_slot [2];
    logic         r_wp, r_rp;
    logic [1:0]   r_cnt;
    logic         w_push, w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_slot[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wp] <= i_data;
        end
    end

endmodule
`default_nettype wire

### design/tpc_back.sv
`default_nettype none
module tpc_back #(
    parameter int MAX_ELEMENTS = tpc_pkg::DEFAULT_MAX_ELEMENTS,
    parameter int AW           = tpc_pkg::addr_width(tpc_pkg::DEFAULT_MAX_ELEMENTS)
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire logic                        i_mode,
    input  tpc_pkg::t_status                 i_status,
    input  wire logic [tpc_pkg::COUNT_W-1:0] i_delta,
    input  wire logic [AW-1:0]               i_idx,
    output logic                             o_clearing,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output logic [tpc_pkg::COUNT_W-1:0]      o_count,
    output tpc_pkg::t_status                 o_status
);
    import tpc_pkg::*;

    localparam int DEPTH = table_depth(MAX_ELEMENTS);

    logic [COUNT_W-1:0] r_table [DEPTH];
    logic [COUNT_W-1:0] r_rdata;

    t_back_state r_state, n_state;
    logic [AW-1:0] r_clr, n_clr;

    logic               r_op_mode;
    t_status            r_op_status;
    logic [COUNT_W-1:0] r_op_delta;
    logic [AW-1:0]      r_op_idx;

    logic               r_out_valid;
    logic [COUNT_W-1:0] r_count;
    t_status            r_status;

    logic               w_pop, w_re, w_we, w_load;
    logic [AW-1:0]      w_waddr;
    logic [COUNT_W-1:0] w_wdata, w_sum, w_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
        end
    end

    always_comb begin
        n_state = r_state;
        n_clr   = r_clr;
        w_pop   = 1'b0;
        w_re    = 1'b0;
        w_we    = 1'b0;
        w_load  = 1'b0;
        w_waddr = r_op_idx;
        w_sum   = r_rdata + r_op_delta;
        w_count = '0;
        if (r_op_status == STAT_OK) begin
            w_count = r_op_mode ? w_sum : r_rdata;
        end
        w_wdata = w_sum;
        case (r_state)
            ST_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr;
                w_wdata = '0;
                n_clr   = r_clr + AW'(1);
                if (r_clr == AW'(DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_valid) begin
                    w_pop   = 1'b1;
                    w_re    = (i_status == STAT_OK);
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (!r_out_valid || i_ready) begin
                    w_load  = 1'b1;
                    w_we    = (r_op_status == STAT_OK) && r_op_mode;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_table[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rdata <= r_table[i_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_op_mode   <= i_mode;
            r_op_status <= i_status;
            r_op_delta  <= i_delta;
            r_op_idx    <= i_idx;
        end
        if (w_load) begin
            r_count  <= w_count;
            r_status <= r_op_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_ready    = w_pop;
    assign o_clearing = (r_state == ST_CLEAR);
    assign o_valid    = r_out_valid;
    assign o_count    = r_count;
    assign o_status   = r_status;

endmodule
`default_nettype wire

### design/triangular_pair_counter.sv
// channel  direction  handshake                    payload
// in       input      i_in_valid / o_in_ready      i_mode, i_first_element,
//                                                  i_second_element, i_delta
// out      output     o_out_valid / i_out_ready    o_count, o_status
// cfg      input      i_cfg_we (no wait)           i_cfg_data
//
// After reset a clearing pass writes zero to all MAX_ELEMENTS*(MAX_ELEMENTS-1)/2 table entries
// (8128 at the default), one entry a cycle; o_in_ready is low then.
// Front: two register stages (classify, index products), then a two-beat queue.
// Back: one table read, then add and write-back; a new beat is taken only after
// the write-back of the last, set by the read-then-write of the single table port pair.
// Each side stalls on its own.
`default_nettype none
module triangular_pair_counter #(
    parameter int MAX_ELEMENTS = tpc_pkg::DEFAULT_MAX_ELEMENTS
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire logic                               i_mode,
    input  wire logic [tpc_pkg::ELEM_W-1:0]         i_first_element,
    input  wire logic [tpc_pkg::ELEM_W-1:0]         i_second_element,
    input  wire logic signed [tpc_pkg::COUNT_W-1:0] i_delta,
    input  wire logic                               i_cfg_we,
    input  wire logic [tpc_pkg::CFG_W-1:0]          i_cfg_data,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic [tpc_pkg::COUNT_W-1:0]             o_count,
    output logic [tpc_pkg::STATUS_W-1:0]            o_status
);
    import tpc_pkg::*;

    localparam int AW = addr_width(MAX_ELEMENTS);
    localparam int QW = 1 + STATUS_W + COUNT_W + AW;

    logic               w_f_valid, w_f_ready, w_f_mode;
    t_status            w_f_status;
    logic [COUNT_W-1:0] w_f_delta;
    logic [AW-1:0]      w_f_idx;

    logic               w_q_valid, w_q_ready;
    logic [QW-1:0]      w_q_in, w_q_out;
    logic               w_clearing;
    t_status            w_out_status;

    tpc_front #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .AW           (AW)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_in_valid),
        .o_ready          (o_in_ready),
        .i_mode           (i_mode),
        .i_first_element  (i_first_element),
        .i_second_element (i_second_element),
        .i_delta          ($unsigned(i_delta)),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .i_hold           (w_clearing),
        .o_valid          (w_f_valid),
        .i_ready          (w_f_ready),
        .o_mode           (w_f_mode),
        .o_status         (w_f_status),
        .o_delta          (w_f_delta),
        .o_idx            (w_f_idx)
    );

    assign w_q_in = {w_f_mode, w_f_status, w_f_delta, w_f_idx};

    tpc_queue #(
        .W (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_f_valid),
        .o_ready (w_f_ready),
        .i_data  (w_q_in),
        .o_valid (w_q_valid),
        .i_ready (w_q_ready),
        .o_data  (w_q_out)
    );

    tpc_back #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .AW           (AW)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_q_valid),
        .o_ready    (w_q_ready),
        .i_mode     (w_q_out[QW-1]),
        .i_status   (t_status'(w_q_out[QW-2 -: STATUS_W])),
        .i_delta    (w_q_out[AW +: COUNT_W]),
        .i_idx      (w_q_out[AW-1:0]),
        .o_clearing (w_clearing),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_count    (o_count),
        .o_status   (w_out_status)
    );

    assign o_status = w_out_status;

endmodule
`default_nettype wire

### test/triangular_pair_counter_test.sv
`timescale 1ns / 100ps
module triangular_pair_counter_test;
    import tpc_pkg::*;

    localparam int MAX_ELEMENTS = 128;
    localparam int TABLE_CELLS  = MAX_ELEMENTS * (MAX_ELEMENTS - 1) / 2;
    localparam int CYCLE_LIMIT  = 400000;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        t_status            status;
    } t_pair_result;

    logic                       i_clk            = 1'b0;
    logic                       i_rst_n          = 1'b0;
    logic                       i_in_valid       = 1'b0;
    logic                       o_in_ready;
    logic                       i_mode           = 1'b0;
    logic [ELEM_W-1:0]          i_first_element  = '0;
    logic [ELEM_W-1:0]          i_second_element = '0;
    logic signed [COUNT_W-1:0]  i_delta          = '0;
    logic                       i_cfg_we         = 1'b0;
    logic [CFG_W-1:0]           i_cfg_data       = '0;
    logic                       o_out_valid;
    logic                       i_out_ready      = 1'b0;
    logic [COUNT_W-1:0]         o_count;
    logic [STATUS_W-1:0]        o_status;

    logic [COUNT_W-1:0] pair_table [TABLE_CELLS];
    logic [CFG_W-1:0]   shadow_element_count = CFG_RESET;
    t_pair_result       pair_results [$];
    int                 errors        = 0;
    int                 cycle_count   = 0;
    int                 send_idle_pct = 0;
    int                 recv_idle_pct = 0;

    triangular_pair_counter #(
        .MAX_ELEMENTS(MAX_ELEMENTS)
    ) u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_mode           (i_mode),
        .i_first_element  (i_first_element),
        .i_second_element (i_second_element),
        .i_delta          (i_delta),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_count          (o_count),
        .o_status         (o_status)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[triangular_pair_counter] ERROR");
            $finish;
        end
    end

    // result beat checker and receiver stall
    always @(posedge i_clk) begin : result_check
        t_pair_result want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (pair_results.size() == 0) begin
                    errors++;
                    $display("%0t unexpected beat: expected none, actual count %h status %0d",
                             $time, o_count, o_status);
                end else begin
                    want = pair_results.pop_front();
                    if (o_count !== want.count) begin
                        errors++;
                        $display("%0t count mismatch: expected %h actual %h",
                                 $time, want.count, o_count);
                    end
                    if (o_status !== want.status) begin
                        errors++;
                        $display("%0t status mismatch: expected %0d actual %0d",
                                 $time, want.status, o_status);
                    end
                end
            end
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic int effective_elements();
        int n;
        n = shadow_element_count;
        if (n < N_MIN) n = N_MIN;
        if (n > MAX_ELEMENTS) n = MAX_ELEMENTS;
        return n;
    endfunction

    task automatic apply_pair_op(input logic mode, input logic [ELEM_W-1:0] e1,
                                 input logic [ELEM_W-1:0] e2, input logic [COUNT_W-1:0] d,
                                 output t_pair_result res);
        int n;
        int a;
        int b;
        int idx;
        n = effective_elements();
        res.count = '0;
        res.status = STAT_OK;
        if (e1 == 0 || e2 == 0) res.status = STAT_ZERO;
        else if (e1 > n || e2 > n) res.status = STAT_ABOVE;
        else if (e1 == e2) res.status = STAT_EQUAL;
        if (res.status == STAT_OK) begin
            a = (e1 < e2) ? e1 : e2;
            b = (e1 < e2) ? e2 : e1;
            idx = (a - 1) * n - ((a - 1) * a) / 2 + (b - a - 1);
            if (idx < TABLE_CELLS) begin
                res.count = pair_table[idx];
                if (mode) begin
                    res.count = res.count + d;
                    pair_table[idx] = res.count;
                end
            end
        end
    endtask

    task automatic send_pair_op(input logic mode, input logic [ELEM_W-1:0] e1,
                                input logic [ELEM_W-1:0] e2, input logic [COUNT_W-1:0] d);
        t_pair_result res;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_mode           <= mode;
        i_first_element  <= e1;
        i_second_element <= e2;
        i_delta          <= d;
        do @(posedge i_clk); while (!o_in_ready);
        apply_pair_op(mode, e1, e2, d, res);
        pair_results.push_back(res);
    endtask

    task automatic wait_results_drained();
        i_in_valid <= 1'b0;
        while (pair_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_element_count(input logic [CFG_W-1:0] value);
        wait_results_drained();
        repeat (2) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        shadow_element_count = value;
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [ELEM_W-1:0] pick_element(input int n);
        int r;
        r = $urandom_range(99);
        if (r < 5) return '0;
        if (r < 10) return ELEM_W'($urandom);
        if (r < 16) return ELEM_W'(n + $urandom_range(1, 3));
        return ELEM_W'($urandom_range(1, n));
    endfunction

    // mostly in-range pairs, many repeats to build up counts and hit back-to-back hazards
    task automatic random_pair_ops(input int beats);
        logic [ELEM_W-1:0]  a;
        logic [ELEM_W-1:0]  b;
        logic [ELEM_W-1:0]  t;
        logic [COUNT_W-1:0] d;
        logic               m;
        int                 n;
        int                 r;
        n = effective_elements();
        a = pick_element(n);
        b = pick_element(n);
        for (int i = 0; i < beats; i++) begin
            r = $urandom_range(99);
            if (r < 30) begin
            end else if (r < 35) begin
                b = a;
            end else if (r < 42) begin
                t = a;
                a = b;
                b = t;
            end else begin
                a = pick_element(n);
                b = pick_element(n);
            end
            m = ($urandom_range(99) < 70);
            if ($urandom_range(1)) d = COUNT_W'($urandom);
            else d = COUNT_W'($urandom_range(0, 15) - 8);
            send_pair_op(m, a, b, d);
            if (i == beats / 2) wait_results_drained();
        end
    endtask

    task automatic test_cleared_table();
        send_pair_op(1'b0, 16'd1, 16'd2, 16'h1234);
        send_pair_op(1'b0, 16'd127, 16'd128, 16'hFFFF);
        send_pair_op(1'b0, 16'd128, 16'd1, 16'h0000);
    endtask

    task automatic test_status_codes();
        send_pair_op(1'b1, 16'd0, 16'd5, 16'd1);
        send_pair_op(1'b0, 16'd5, 16'd0, 16'd0);
        send_pair_op(1'b1, 16'd0, 16'd0, 16'd7);
        send_pair_op(1'b0, 16'd0, 16'hFFFF, 16'd0);
        send_pair_op(1'b1, 16'd129, 16'd3, 16'd9);
        send_pair_op(1'b0, 16'hFFFF, 16'hFFFF, 16'd0);
        send_pair_op(1'b1, 16'd3, 16'd129, 16'd2);
        send_pair_op(1'b1, 16'd7, 16'd7, 16'd4);
        send_pair_op(1'b0, 16'd128, 16'd128, 16'd0);
    endtask

    task automatic test_count_wrap();
        send_pair_op(1'b1, 16'd1, 16'd2, 16'h7FFF);
        send_pair_op(1'b1, 16'd2, 16'd1, 16'h0001);
        send_pair_op(1'b1, 16'd1, 16'd2, 16'h8000);
        send_pair_op(1'b1, 16'd128, 16'd127, 16'hFFFF);
        send_pair_op(1'b1, 16'd127, 16'd128, 16'h0001);
        send_pair_op(1'b0, 16'd1, 16'd128, 16'h5555);
    endtask

    // clamping of the element count read from the register, and remapping of cells that are kept
    task automatic test_element_count();
        write_element_count(8'd0);
        send_pair_op(1'b1, 16'd1, 16'd2, 16'd5);
        send_pair_op(1'b0, 16'd1, 16'd3, 16'd0);
        write_element_count(8'd1);
        send_pair_op(1'b0, 16'd2, 16'd1, 16'd0);
        write_element_count(8'd255);
        send_pair_op(1'b1, 16'd1, 16'd128, 16'd3);
        write_element_count(8'd4);
        send_pair_op(1'b1, 16'd3, 16'd4, 16'd11);
        write_element_count(8'd5);
        send_pair_op(1'b0, 16'd2, 16'd3, 16'd0);
        send_pair_op(1'b0, 16'd5, 16'd6, 16'd0);
        write_element_count(8'd128);
        send_pair_op(1'b0, 16'd1, 16'd7, 16'd0);
    endtask

    task automatic test_random_traffic(input int sender_pct, input int receiver_pct,
                                       input logic [CFG_W-1:0] n0, input logic [CFG_W-1:0] n1,
                                       input logic [CFG_W-1:0] n2);
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
        write_element_count(n0);
        random_pair_ops(95);
        write_element_count(n1);
        random_pair_ops(95);
        write_element_count(n2);
        random_pair_ops(95);
    endtask

    initial begin
        foreach (pair_table[i]) pair_table[i] = '0;
        send_idle_pct = 8;
        recv_idle_pct = 79;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_cleared_table();
        test_status_codes();
        test_count_wrap();
        test_element_count();
        test_random_traffic(8, 79, 8'd128, 8'd5, 8'd2);
        test_random_traffic(79, 8, 8'd255, 8'd0, 8'($urandom_range(3, 127)));
        test_random_traffic(0, 0, 8'd16, 8'd1, 8'd128);

        wait_results_drained();
        repeat (20) @(posedge i_clk);
        if (errors == 0) begin
            $display("[triangular_pair_counter] OK");
        end else begin
            $display("[triangular_pair_counter] ERROR");
        end
        $finish;
    end
endmodule

### files.f
design/tpc_pkg.sv
design/tpc_front.sv
design/tpc_queue.sv
design/tpc_back.sv
design/triangular_pair_counter.sv
test/triangular_pair_counter_test.sv
